// ===== src/kblru_pkg.sv =====
`timescale 1ns / 1ps

package kblru_pkg;

    localparam logic       CMD_UPDATE   = 1'b0;
    localparam logic       CMD_TICK     = 1'b1;

    localparam logic [1:0] ACT_MOVED    = 2'd0;
    localparam logic [1:0] ACT_APPENDED = 2'd1;
    localparam logic [1:0] ACT_PINGED   = 2'd2;
    localparam logic [1:0] ACT_TICKED   = 2'd3;

    localparam logic [15:0] WAIT_TICKS_RESET = 16'd10;
    localparam logic [3:0]  REPLACED_MAX     = 4'd15;

    typedef struct packed {
        logic        cmd;
        logic [31:0] node_id;
    } kblru_req_t;

    typedef struct packed {
        logic [1:0]  action;
        logic        ping_valid;
        logic [31:0] ping_node;
        logic [3:0]  replaced_count;
    } kblru_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_PICK,
        ST_APPLY
    } kblru_state_t;

    typedef struct packed {
        logic load;
        logic match;
        logic pick;
        logic apply;
    } kblru_ctrl_t;

    typedef struct packed {
        logic out_free;
    } kblru_status_t;

endpackage

// ===== src/kblru_ctrl.sv =====
`timescale 1ns / 1ps

module kblru_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  kblru_pkg::kblru_status_t status,
    output kblru_pkg::kblru_ctrl_t   ctrl
);
    import kblru_pkg::*;

    kblru_state_t state_reg;
    kblru_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        req_stall  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                ctrl.match = 1'b1;
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                ctrl.pick  = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                // commit only when the result register can take the result
                if (status.out_free)
                begin
                    ctrl.apply = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/kblru_dp.sv =====
`timescale 1ns / 1ps

module kblru_dp #(
    parameter int BUCKET_SIZE = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  kblru_pkg::kblru_req_t    req,
    input  logic                     cfg_valid,
    input  logic [15:0]              cfg_data,
    input  kblru_pkg::kblru_ctrl_t   ctrl,
    output kblru_pkg::kblru_status_t status,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output kblru_pkg::kblru_rsp_t    rsp
);
    import kblru_pkg::*;

    localparam int RW = (BUCKET_SIZE > 1) ? $clog2(BUCKET_SIZE) : 1;
    localparam int CW = $clog2(BUCKET_SIZE + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(BUCKET_SIZE);

    // table state
    logic [31:0]      node_reg  [BUCKET_SIZE];
    logic [31:0]      node_next [BUCKET_SIZE];
    logic [31:0]      cand_reg  [BUCKET_SIZE];
    logic [31:0]      cand_next [BUCKET_SIZE];
    logic [RW-1:0]    rank_reg  [BUCKET_SIZE];
    logic [RW-1:0]    rank_next [BUCKET_SIZE];
    logic [15:0]      cd_reg    [BUCKET_SIZE];
    logic [15:0]      cd_next   [BUCKET_SIZE];
    logic [BUCKET_SIZE-1:0] resv_reg;
    logic [BUCKET_SIZE-1:0] resv_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [15:0]      wait_reg;
    logic [15:0]      wait_next;

    // per-item working registers
    kblru_req_t             req_reg;
    logic [BUCKET_SIZE-1:0] hit_reg;
    logic [BUCKET_SIZE-1:0] hit_next;
    logic [BUCKET_SIZE-1:0] expire_reg;
    logic [BUCKET_SIZE-1:0] expire_next;
    logic [BUCKET_SIZE-1:0] tgt_reg;
    logic [BUCKET_SIZE-1:0] tgt_next;
    logic [RW-1:0]          tgt_rank_reg;
    logic [RW-1:0]          tgt_rank_next;
    logic                   any_hit_reg;
    logic                   any_hit_next;
    logic [31:0]            ping_node_reg;
    logic [31:0]            ping_node_next;
    logic [3:0]             replaced_reg;
    logic [3:0]             replaced_next;

    kblru_rsp_t rsp_reg;
    kblru_rsp_t rsp_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    logic [BUCKET_SIZE-1:0] live;
    logic [BUCKET_SIZE-1:0] hit_by_rank;
    logic [BUCKET_SIZE-1:0] oldest;
    logic [RW-1:0]          sel_rank;
    logic [5:0]             pop;
    logic                   full;
    logic [CW-1:0]          last_rank;

    assign full      = (count_reg == FULL_COUNT);
    assign last_rank = count_reg - CW'(1);

    always_comb
    begin
        for (int i = 0; i < BUCKET_SIZE; i++)
        begin
            live[i] = (CW'(i) < count_reg);
        end
    end

    // compare stage: one comparator per entry
    always_comb
    begin
        for (int i = 0; i < BUCKET_SIZE; i++)
        begin
            hit_next[i]    = live[i] && (node_reg[i] == req_reg.node_id);
            expire_next[i] = live[i] && resv_reg[i] && (cd_reg[i] <= 16'd1);
        end
    end

    // select stage: ranks are unique among live entries, so the oldest hit is
    // the lowest rank that has a hit
    always_comb
    begin
        hit_by_rank = '0;
        for (int r = 0; r < BUCKET_SIZE; r++)
        begin
            for (int i = 0; i < BUCKET_SIZE; i++)
            begin
                if (hit_reg[i] && (rank_reg[i] == RW'(r)))
                begin
                    hit_by_rank[r] = 1'b1;
                end
            end
        end
        sel_rank = '0;
        for (int r = BUCKET_SIZE - 1; r >= 0; r--)
        begin
            if (hit_by_rank[r])
            begin
                sel_rank = RW'(r);
            end
        end
        for (int i = 0; i < BUCKET_SIZE; i++)
        begin
            oldest[i] = live[i] && (rank_reg[i] == '0);
        end
        any_hit_next   = |hit_reg;
        ping_node_next = '0;
        for (int i = 0; i < BUCKET_SIZE; i++)
        begin
            if (oldest[i])
            begin
                ping_node_next = ping_node_next | node_reg[i];
            end
        end
        for (int i = 0; i < BUCKET_SIZE; i++)
        begin
            tgt_next[i] = any_hit_next ? (hit_reg[i] && (rank_reg[i] == sel_rank))
                                       : oldest[i];
        end
        tgt_rank_next = any_hit_next ? sel_rank : '0;
        pop           = 6'($countones(expire_reg));
        replaced_next = (pop > 6'(REPLACED_MAX)) ? REPLACED_MAX : pop[3:0];
    end

    // apply stage: table update and result
    always_comb
    begin
        node_next      = node_reg;
        cand_next      = cand_reg;
        rank_next      = rank_reg;
        cd_next        = cd_reg;
        resv_next      = resv_reg;
        count_next     = count_reg;
        wait_next      = wait_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        if (cfg_valid)
        begin
            wait_next = cfg_data;
        end

        if (ctrl.apply)
        begin
            rsp_valid_next          = 1'b1;
            rsp_next.ping_valid     = 1'b0;
            rsp_next.ping_node      = '0;
            rsp_next.replaced_count = '0;
            if (req_reg.cmd == CMD_TICK)
            begin
                rsp_next.action         = ACT_TICKED;
                rsp_next.replaced_count = replaced_reg;
                for (int i = 0; i < BUCKET_SIZE; i++)
                begin
                    if (live[i] && resv_reg[i])
                    begin
                        if (expire_reg[i])
                        begin
                            cd_next[i]   = '0;
                            node_next[i] = cand_reg[i];
                            resv_next[i] = 1'b0;
                        end
                        else
                        begin
                            cd_next[i] = cd_reg[i] - 16'd1;
                        end
                    end
                end
            end
            else if (any_hit_reg || full)
            begin
                // move target to the recent end; full case also reserves it
                rsp_next.action = any_hit_reg ? ACT_MOVED : ACT_PINGED;
                for (int i = 0; i < BUCKET_SIZE; i++)
                begin
                    if (tgt_reg[i])
                    begin
                        rank_next[i] = last_rank[RW-1:0];
                        if (!any_hit_reg)
                        begin
                            resv_next[i] = 1'b1;
                            cand_next[i] = req_reg.node_id;
                            cd_next[i]   = wait_reg;
                        end
                    end
                    else if (live[i] && (rank_reg[i] > tgt_rank_reg))
                    begin
                        rank_next[i] = rank_reg[i] - RW'(1);
                    end
                end
                if (!any_hit_reg)
                begin
                    rsp_next.ping_valid = 1'b1;
                    rsp_next.ping_node  = ping_node_reg;
                end
            end
            else
            begin
                rsp_next.action = ACT_APPENDED;
                for (int i = 0; i < BUCKET_SIZE; i++)
                begin
                    if (CW'(i) == count_reg)
                    begin
                        node_next[i] = req_reg.node_id;
                        rank_next[i] = count_reg[RW-1:0];
                        resv_next[i] = 1'b0;
                        cd_next[i]   = '0;
                    end
                end
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUCKET_SIZE; i++)
            begin
                rank_reg[i] <= '0;
                cd_reg[i]   <= '0;
            end
            resv_reg      <= '0;
            count_reg     <= '0;
            wait_reg      <= WAIT_TICKS_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rank_reg      <= rank_next;
            cd_reg        <= cd_next;
            resv_reg      <= resv_next;
            count_reg     <= count_next;
            wait_reg      <= wait_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        cand_reg <= cand_next;
        rsp_reg  <= rsp_next;
        if (ctrl.load)
        begin
            req_reg <= req;
        end
        if (ctrl.match)
        begin
            hit_reg    <= hit_next;
            expire_reg <= expire_next;
        end
        if (ctrl.pick)
        begin
            tgt_reg       <= tgt_next;
            tgt_rank_reg  <= tgt_rank_next;
            any_hit_reg   <= any_hit_next;
            ping_node_reg <= ping_node_next;
            replaced_reg  <= replaced_next;
        end
    end

    assign status.out_free = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid       = rsp_valid_reg;
    assign rsp             = rsp_reg;

endmodule

// ===== src/kademlia_bucket_lru_update.sv =====
`timescale 1ns / 1ps

// Least-recently-seen peer table of BUCKET_SIZE entries held in flip-flops,
// with one handle comparator per entry. Each request (an update or a tick)
// goes through capture, parallel compare, oldest-hit/oldest-entry select,
// and commit of the table change together with the result. A result that
// is still stalled holds the commit back, but the block takes the next
// request as soon as the previous result sits in the output register; a new
// request is not taken before the previous one is committed. wait_ticks is
// written over the cfg channel, which is always ready and must only be used
// while no request is in flight; it resets to 10.
module kademlia_bucket_lru_update #(
    parameter int BUCKET_SIZE = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  kblru_pkg::kblru_req_t req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output kblru_pkg::kblru_rsp_t rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [15:0]           cfg_data
);
    import kblru_pkg::*;

    kblru_ctrl_t   ctrl;
    kblru_status_t status;

    assign cfg_ready = 1'b1;

    kblru_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .ctrl      (ctrl)
    );

    kblru_dp #(
        .BUCKET_SIZE (BUCKET_SIZE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
